// ----- design/assert_macros.svh -----
// assertion macros used by the dihedral angle design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- design/dha_pkg.sv -----
// shared types, widths and constants of the dihedral angle pipeline
package dha_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int NORM_BITS   = 40;
  localparam int STEPS       = 24;
  localparam int CR_PER_STG  = 3;
  localparam int CR_STAGES   = STEPS / CR_PER_STG;
  localparam int SQ_PER_STG  = 4;
  localparam int SQ_STAGES   = NORM_BITS / SQ_PER_STG;
  localparam int RAD_W       = 2 * NORM_BITS;
  localparam int REM_W       = NORM_BITS + 2;
  localparam int XY_W        = NORM_BITS + 4;
  localparam int Z_W         = 27;
  localparam int ANG90       = 11796480;
  localparam int ANG180      = 23592960;
  localparam int TH_W        = 16;
  localparam int OUT_W       = 16;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] a_x;
    logic signed [COORD_WIDTH-1:0] a_y;
    logic signed [COORD_WIDTH-1:0] a_z;
    logic signed [COORD_WIDTH-1:0] b_x;
    logic signed [COORD_WIDTH-1:0] b_y;
    logic signed [COORD_WIDTH-1:0] b_z;
    logic signed [COORD_WIDTH-1:0] c_x;
    logic signed [COORD_WIDTH-1:0] c_y;
    logic signed [COORD_WIDTH-1:0] c_z;
    logic signed [COORD_WIDTH-1:0] d_x;
    logic signed [COORD_WIDTH-1:0] d_y;
    logic signed [COORD_WIDTH-1:0] d_z;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] torsion;
    logic                    degenerate;
  } out_t;

  typedef struct packed {
    logic deg;
    logic xneg;
    logic wneg;
  } flag_t;

  typedef struct packed {
    logic [RAD_W-1:0]     rad;
    logic [NORM_BITS-1:0] root;
    logic [REM_W-1:0]     rem;
  } sq_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cr_t;

  // atan(2^-i) in 1/131072 degree
  function automatic logic [23:0] atan_val(input int i);
    logic [23:0] r;
    case (i)
      0:  r = 24'd5898240;
      1:  r = 24'd3481934;
      2:  r = 24'd1839759;
      3:  r = 24'd933890;
      4:  r = 24'd468757;
      5:  r = 24'd234607;
      6:  r = 24'd117332;
      7:  r = 24'd58670;
      8:  r = 24'd29335;
      9:  r = 24'd14668;
      10: r = 24'd7334;
      11: r = 24'd3667;
      12: r = 24'd1833;
      13: r = 24'd917;
      14: r = 24'd458;
      15: r = 24'd229;
      16: r = 24'd115;
      17: r = 24'd57;
      18: r = 24'd29;
      19: r = 24'd14;
      20: r = 24'd7;
      21: r = 24'd4;
      22: r = 24'd2;
      23: r = 24'd1;
      default: r = 24'd0;
    endcase
    return r;
  endfunction

  // four digits of the restoring square root
  function automatic sq_t sqrt_step(input sq_t s_in);
    sq_t s;
    logic [REM_W+1:0] rt;
    logic [REM_W+1:0] tt;
    s = s_in;
    for (int j = 0; j < SQ_PER_STG; j++) begin
      rt = {s.rem, s.rad[RAD_W-1 -: 2]};
      tt = (REM_W+2)'({s.root, 2'b01});
      s.rad = {s.rad[RAD_W-3:0], 2'b00};
      if (rt >= tt) begin
        s.rem  = REM_W'(rt - tt);
        s.root = {s.root[NORM_BITS-2:0], 1'b1};
      end else begin
        s.rem  = REM_W'(rt);
        s.root = {s.root[NORM_BITS-2:0], 1'b0};
      end
    end
    return s;
  endfunction

  // three vectoring iterations starting at iteration base
  function automatic cr_t cordic_step(input cr_t s_in, input int base);
    cr_t s;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    s = s_in;
    for (int j = 0; j < CR_PER_STG; j++) begin
      dx = s.y >>> (base + j);
      dy = s.x >>> (base + j);
      if (!s.y[XY_W-1]) begin
        s.x = s.x + dx;
        s.y = s.y - dy;
        s.z = s.z + Z_W'(atan_val(base + j));
      end else begin
        s.x = s.x - dx;
        s.y = s.y + dy;
        s.z = s.z - Z_W'(atan_val(base + j));
      end
    end
    return s;
  endfunction

endpackage

// ----- design/dihedral_angle_four_points.sv -----
// Dihedral angle of four points: one point quadruple in, one signed angle out.
// The input channel (in_valid, in_stall, in_item) carries the twelve coordinates
// of points a, b, c, d; the output channel (out_valid, out_stall, out_item) carries
// the torsion angle in 1/128 degree and the degenerate flag.
// A transfer happens at a clock edge where valid is high and stall is low.
// The block is a 39-stage pipeline: a result is shown from the output register of
// the last stage; one item can be taken every cycle while out_stall does not hold
// the pipeline, so throughput is one per cycle.
// Depth is set by the product chain (cross products, dot products, the square of
// the normal dot and its scaling, each through a pipelined multiplier), the
// leading-one search and shifts, ten square root stages of four digits each and
// eight CORDIC stages of three iterations each.
// When out_stall is high while a result is shown, the whole pipeline holds and
// in_stall goes high in the same cycle; nothing is dropped or repeated.
// cfg_we writes zero_length_threshold from cfg_wdata; write it only while idle.
// Synchronous reset (rst) empties the pipeline and sets the threshold to 1.
module dihedral_angle_four_points import dha_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  in_t             in_item,
  output logic            out_valid,
  input  logic            out_stall,
  output out_t            out_item,
  input  logic            cfg_we,
  input  logic [TH_W-1:0] cfg_wdata
);

  `include "assert_macros.svh"

  localparam int CW    = COORD_WIDTH;
  localparam int DW    = CW + 1;
  localparam int PD    = 2 * DW;
  localparam int VW    = PD + 1;
  localparam int PV    = 2 * VW;
  localparam int NW    = PV + 2;
  localparam int PVC   = VW + DW;
  localparam int WW    = PVC + 2;
  localparam int SW    = PD + 2;
  localparam int W2W   = 2 * WW;
  localparam int YW    = SW + W2W;
  localparam int BLW   = $clog2(YW + 1);
  localparam int CK    = 16;
  localparam int NCX   = (NW + CK - 1) / CK;
  localparam int NCY   = (YW + CK - 1) / CK;
  localparam int DEPTH = 39;

  logic             en;
  logic [DEPTH-1:0] vld;
  logic [2*TH_W-1:0] thresh_sq;

  assign en        = !(vld[DEPTH-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      thresh_sq <= (2*TH_W)'(1);
    end else begin
      if (en) vld <= {vld[DEPTH-2:0], in_valid};
      if (cfg_we) thresh_sq <= cfg_wdata * cfg_wdata;
    end
  end

  // stage 1: differences
  logic signed [DW-1:0] c1 [3];
  logic signed [DW-1:0] c2 [3];
  logic signed [DW-1:0] c3 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      c1[0] <= DW'(in_item.a_x) - DW'(in_item.b_x);
      c1[1] <= DW'(in_item.a_y) - DW'(in_item.b_y);
      c1[2] <= DW'(in_item.a_z) - DW'(in_item.b_z);
      c2[0] <= DW'(in_item.b_x) - DW'(in_item.c_x);
      c2[1] <= DW'(in_item.b_y) - DW'(in_item.c_y);
      c2[2] <= DW'(in_item.b_z) - DW'(in_item.c_z);
      c3[0] <= DW'(in_item.c_x) - DW'(in_item.d_x);
      c3[1] <= DW'(in_item.c_y) - DW'(in_item.d_y);
      c3[2] <= DW'(in_item.c_z) - DW'(in_item.d_z);
    end
  end

  // stages 2-4: cross product terms and c2 squares
  logic signed [DW-1:0] xa [15];
  logic signed [DW-1:0] xb [15];
  logic signed [PD-1:0] xp [15];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      xa[2*k]     = c2[(k+1)%3];  xb[2*k]     = c1[(k+2)%3];
      xa[2*k+1]   = c2[(k+2)%3];  xb[2*k+1]   = c1[(k+1)%3];
      xa[6+2*k]   = c3[(k+1)%3];  xb[6+2*k]   = c2[(k+2)%3];
      xa[6+2*k+1] = c3[(k+2)%3];  xb[6+2*k+1] = c2[(k+1)%3];
      xa[12+k]    = c2[k];        xb[12+k]    = c2[k];
    end
  end

  for (genvar g = 0; g < 15; g++) begin : g_xmul
    dha_mul #(.AW(DW), .BW(DW)) u_mul (
      .clk(clk), .en(en), .a(xa[g]), .b(xb[g]), .p(xp[g])
    );
  end

  logic signed [DW-1:0] c1_d [2:5][3];

  always_ff @(posedge clk) begin
    if (en) begin
      c1_d[2] <= c1;
      for (int s = 3; s <= 5; s++) c1_d[s] <= c1_d[s-1];
    end
  end

  // stage 5: plane normals and |c2|^2
  logic signed [VW-1:0] v1 [3];
  logic signed [VW-1:0] v2 [3];
  logic signed [SW-1:0] c2sq_d [5:12];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        v1[k] <= VW'(xp[2*k]) - VW'(xp[2*k+1]);
        v2[k] <= VW'(xp[6+2*k]) - VW'(xp[6+2*k+1]);
      end
      c2sq_d[5] <= SW'(xp[12]) + SW'(xp[13]) + SW'(xp[14]);
      for (int s = 6; s <= 12; s++) c2sq_d[s] <= c2sq_d[s-1];
    end
  end

  // stages 6-8: dot product terms
  logic signed [VW-1:0]  da [9];
  logic signed [VW-1:0]  db [9];
  logic signed [PV-1:0]  dp [9];
  logic signed [PVC-1:0] wp [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      da[k]   = v1[k];  db[k]   = v1[k];
      da[3+k] = v2[k];  db[3+k] = v2[k];
      da[6+k] = v1[k];  db[6+k] = v2[k];
    end
  end

  for (genvar g = 0; g < 9; g++) begin : g_dmul
    dha_mul #(.AW(VW), .BW(VW)) u_mul (
      .clk(clk), .en(en), .a(da[g]), .b(db[g]), .p(dp[g])
    );
  end

  for (genvar g = 0; g < 3; g++) begin : g_wmul
    dha_mul #(.AW(VW), .BW(DW)) u_mul (
      .clk(clk), .en(en), .a(v2[g]), .b(c1_d[5][g]), .p(wp[g])
    );
  end

  // stage 9: dot sums
  logic signed [NW-1:0] n1;
  logic signed [NW-1:0] n2;
  logic signed [NW-1:0] xdot;
  logic signed [WW-1:0] wdot;

  always_ff @(posedge clk) begin
    if (en) begin
      n1   <= NW'(dp[0]) + NW'(dp[1]) + NW'(dp[2]);
      n2   <= NW'(dp[3]) + NW'(dp[4]) + NW'(dp[5]);
      xdot <= NW'(dp[6]) + NW'(dp[7]) + NW'(dp[8]);
      wdot <= WW'(wp[0]) + WW'(wp[1]) + WW'(wp[2]);
    end
  end

  // stages 10-12: w squared; stage 10 also takes flags and |X|
  logic signed [W2W-1:0] w2;
  flag_t                 fl [10:38];
  logic [NW-1:0]         ax_d [10:18];

  dha_mul #(.AW(WW), .BW(WW)) u_w2 (
    .clk(clk), .en(en), .a(wdot), .b(wdot), .p(w2)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      fl[10].deg  <= ($unsigned(n1) <= NW'(thresh_sq)) ||
                     ($unsigned(n2) <= NW'(thresh_sq));
      fl[10].xneg <= xdot[NW-1];
      fl[10].wneg <= wdot[WW-1];
      ax_d[10]    <= xdot[NW-1] ? NW'(-xdot) : NW'(xdot);
      for (int s = 11; s <= 38; s++) fl[s] <= fl[s-1];
      for (int s = 11; s <= 18; s++) ax_d[s] <= ax_d[s-1];
    end
  end

  // stages 13-15: Y^2 = |c2|^2 * w^2
  logic signed [YW-1:0] ysq;
  logic [YW-1:0]        y_d [16:18];

  dha_mul #(.AW(SW), .BW(W2W)) u_ysq (
    .clk(clk), .en(en), .a(c2sq_d[12]), .b(w2), .p(ysq)
  );

  // stage 16: per-chunk leading one
  logic [NCX*CK-1:0]  axp;
  logic [NCY*CK-1:0]  yp;
  logic [NCX-1:0]     xnz_next, xnz;
  logic [NCY-1:0]     ynz_next, ynz;
  logic [3:0]         xpos_next [NCX];
  logic [3:0]         xpos [NCX];
  logic [3:0]         ypos_next [NCY];
  logic [3:0]         ypos [NCY];

  assign axp = (NCX*CK)'(ax_d[15]);
  assign yp  = (NCY*CK)'($unsigned(ysq));

  always_comb begin
    for (int c = 0; c < NCX; c++) begin
      xnz_next[c]  = |axp[c*CK +: CK];
      xpos_next[c] = '0;
      for (int b = 0; b < CK; b++) begin
        if (axp[c*CK + b]) xpos_next[c] = 4'(b);
      end
    end
    for (int c = 0; c < NCY; c++) begin
      ynz_next[c]  = |yp[c*CK +: CK];
      ypos_next[c] = '0;
      for (int b = 0; b < CK; b++) begin
        if (yp[c*CK + b]) ypos_next[c] = 4'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xnz      <= xnz_next;
      xpos     <= xpos_next;
      ynz      <= ynz_next;
      ypos     <= ypos_next;
      y_d[16]  <= $unsigned(ysq);
      y_d[17]  <= y_d[16];
      y_d[18]  <= y_d[17];
    end
  end

  // stage 17: bit lengths
  logic [BLW-1:0] bx_next, by_next, bx, by;

  always_comb begin
    bx_next = '0;
    by_next = '0;
    for (int c = 0; c < NCX; c++) begin
      if (xnz[c]) bx_next = BLW'(c * CK) + BLW'(xpos[c]) + BLW'(1);
    end
    for (int c = 0; c < NCY; c++) begin
      if (ynz[c]) by_next = BLW'(c * CK) + BLW'(ypos[c]) + BLW'(1);
    end
  end

  // stage 18: normalizing shift
  logic [BLW-1:0] hy, top, kshift;

  assign hy  = BLW'((BLW+1)'(by) + (BLW+1)'(1) >> 1);
  assign top = (bx > hy) ? bx : hy;

  always_ff @(posedge clk) begin
    if (en) begin
      bx     <= bx_next;
      by     <= by_next;
      kshift <= (top > BLW'(NORM_BITS)) ? top - BLW'(NORM_BITS) : '0;
    end
  end

  // stage 19: scaled operands, stages 20-29: square root
  logic [NW-1:0]        xs_full;
  logic [YW-1:0]        ys_full;
  logic [NORM_BITS-1:0] xs_d [19:29];
  sq_t                  sq [19:29];

  assign xs_full = ax_d[18] >> kshift;
  assign ys_full = y_d[18] >> {kshift, 1'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      xs_d[19]     <= xs_full[NORM_BITS-1:0];
      sq[19].rad   <= ys_full[RAD_W-1:0];
      sq[19].root  <= '0;
      sq[19].rem   <= '0;
      for (int s = 20; s <= 29; s++) begin
        xs_d[s] <= xs_d[s-1];
        sq[s]   <= sqrt_step(sq[s-1]);
      end
    end
  end

  // stage 30: quadrant fix, stages 31-38: CORDIC
  cr_t cr [30:38];

  always_ff @(posedge clk) begin
    if (en) begin
      if (fl[29].xneg) begin
        cr[30].x <= XY_W'(sq[29].root);
        cr[30].y <= XY_W'(xs_d[29]);
        cr[30].z <= Z_W'(ANG90);
      end else begin
        cr[30].x <= XY_W'(xs_d[29]);
        cr[30].y <= XY_W'(sq[29].root);
        cr[30].z <= '0;
      end
      for (int s = 31; s <= 38; s++) begin
        cr[s] <= cordic_step(cr[s-1], (s - 31) * CR_PER_STG);
      end
    end
  end

  // stage 39: clamp, round, sign
  logic signed [Z_W-1:0] zc;
  logic [Z_W-1:0]        zr;
  logic signed [OUT_W-1:0] tmag;

  always_comb begin
    if (cr[38].z < 0) zc = '0;
    else if (cr[38].z > Z_W'(ANG180)) zc = Z_W'(ANG180);
    else zc = cr[38].z;
    zr   = $unsigned(zc) + Z_W'(512);
    tmag = OUT_W'(zr >> 10);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item.degenerate <= fl[38].deg;
      if (fl[38].deg) out_item.torsion <= '0;
      else if (fl[38].wneg) out_item.torsion <= -tmag;
      else out_item.torsion <= tmag;
    end
  end

  `ASSERT_IMPLIES(a_deg_zero, clk, rst, out_valid && out_item.degenerate,
                  out_item.torsion == '0, "degenerate result with nonzero angle")
  `ASSERT_IMPLIES(a_range, clk, rst, out_valid,
                  out_item.torsion >= -16'sd23040 && out_item.torsion <= 16'sd23040,
                  "torsion out of range")
  `ASSERT_IMPLIES(a_backpress, clk, rst, out_valid && out_stall, in_stall,
                  "pipeline accepts while output is held")

endmodule

// ----- design/dha_mul.sv -----
// pipelined signed multiplier built from 33x33 partial products; products, row sums and result are registered
module dha_mul import dha_pkg::*; #(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [AW-1:0]      a,
  input  logic signed [BW-1:0]      b,
  output logic signed [AW+BW-1:0]   p
);

  localparam int CH = 32;
  localparam int NA = (AW + CH - 1) / CH;
  localparam int NB = (BW + CH - 1) / CH;
  localparam int PW = AW + BW;

  logic signed [NA*CH-1:0] ae;
  logic signed [NB*CH-1:0] be;
  logic signed [CH:0]      sa [NA];
  logic signed [CH:0]      sb [NB];
  logic signed [2*CH+1:0]  pp [NA][NB];
  logic signed [PW-1:0]    row_next [NA];
  logic signed [PW-1:0]    row [NA];
  logic signed [PW-1:0]    p_next;

  assign ae = (NA*CH)'(a);
  assign be = (NB*CH)'(b);

  // low chunks are unsigned, the top chunk carries the sign
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      sa[i] = {(i == NA - 1) ? ae[i*CH + CH - 1] : 1'b0, ae[i*CH +: CH]};
    end
    for (int j = 0; j < NB; j++) begin
      sb[j] = {(j == NB - 1) ? be[j*CH + CH - 1] : 1'b0, be[j*CH +: CH]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i][j] <= sa[i] * sb[j];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_next[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_next[i] = row_next[i] + (PW'(pp[i][j]) <<< (CH * j));
      end
    end
    p_next = '0;
    for (int i = 0; i < NA; i++) begin
      p_next = p_next + (row[i] <<< (CH * i));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      row <= row_next;
      p   <= p_next;
    end
  end

endmodule
